// ===== rtl/ascp_pkg.sv =====
// Shared constants and types for the ASCII setpoint command parser.
package ascp_pkg;

  // Field widths of the result request
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned LETTER_W = 8;
  localparam int unsigned VALUE_W  = 25;
  localparam int unsigned MAG_W    = 24;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // Character codes
  localparam logic [7:0] ASC_NL    = 8'h0A;
  localparam logic [7:0] ASC_TAB   = 8'h09;
  localparam logic [7:0] ASC_CR    = 8'h0D;
  localparam logic [7:0] ASC_SPACE = 8'h20;
  localparam logic [7:0] ASC_PLUS  = 8'h2B;
  localparam logic [7:0] ASC_MINUS = 8'h2D;
  localparam logic [7:0] ASC_ZERO  = 8'h30;
  localparam logic [7:0] ASC_NINE  = 8'h39;
  localparam logic [7:0] ASC_T     = 8'h54;
  localparam logic [7:0] ASC_P     = 8'h50;
  localparam logic [7:0] ASC_R     = 8'h52;
  localparam logic [7:0] ASC_Y     = 8'h59;

  // Command codes
  localparam logic [CODE_W-1:0] CMD_NONE     = 3'd0;
  localparam logic [CODE_W-1:0] CMD_THROTTLE = 3'd1;
  localparam logic [CODE_W-1:0] CMD_PITCH    = 3'd2;
  localparam logic [CODE_W-1:0] CMD_ROLL     = 3'd3;
  localparam logic [CODE_W-1:0] CMD_YAW      = 3'd4;

  localparam logic signed [VALUE_W-1:0] THROTTLE_RESET = 25'sd1000;

  // Number scanner phase
  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

endpackage

// ===== rtl/ascii_setpoint_command_parser_top.sv =====
// Line assembler and decimal parser for setpoint commands arriving as serial bytes.
//
// Usage: received characters enter one per request on the in_ stream. A line
// ends with newline; its first byte is the command letter and the next
// NUMBER_CHARS bytes are scanned as a signed decimal (whitespace skip, one
// sign, digits up to the first non-digit). Each newline yields one out_
// request with the command code, letter, value and all four setpoints after
// the update; other bytes yield nothing. A line that reaches LINE_LENGTH
// bytes without newline is dropped silently.
// Path: a newline passes the input register, then the result register,
// before it appears on out_.
// Throughput: one byte per cycle while no newline is held (see Stall), set
// by the combinational scan and multiply-by-ten update between the two registers.
// Reset: line state cleared, throttle setpoint 1000, other setpoints 0.
// Stall: while a result waits on out_, the input register keeps taking
// bytes; non-newline bytes keep flowing, and in_tready drops only when
// a held newline cannot move into the occupied result register.
module ascii_setpoint_command_parser_top
  import ascp_pkg::*;
#(
  parameter int unsigned LINE_LENGTH  = 32,
  parameter int unsigned NUMBER_CHARS = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] command_code, [10:3] command_letter, [35:11] parsed_value,
  // [60:36] throttle_setpoint, [85:61] pitch_setpoint,
  // [110:86] roll_setpoint, [135:111] yaw_setpoint
  output logic [135:0] out_tdata
);

  localparam int unsigned POS_W     = $clog2(LINE_LENGTH);
  localparam int unsigned LINE_LAST = LINE_LENGTH - 1;

  // Input register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;

  // Line state
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [LETTER_W-1:0] letter_r, letter_nxt;
  phase_t              phase_r, phase_nxt;
  logic                neg_r, neg_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;

  // Setpoints
  logic signed [VALUE_W-1:0] thr_r, pitch_r, roll_r, yaw_r;

  // Result register
  logic                out_vld_r;
  logic [CODE_W-1:0]   out_code_r, code_nxt;
  logic [LETTER_W-1:0] out_letter_r;
  logic [VALUE_W-1:0]  out_value_r;

  logic               is_nl, is_space, is_digit, is_sign, in_window;
  logic               s1_adv, s1_take, s1_nl_take;
  logic [MAG_W+3:0]   mag_sum;
  logic [VALUE_W-1:0] mag_ext, value;

  // Byte classification
  assign is_nl    = (s1_byte_r == ASC_NL);
  assign is_space = (s1_byte_r == ASC_SPACE) ||
                    ((s1_byte_r >= ASC_TAB) && (s1_byte_r <= ASC_CR));
  assign is_digit = (s1_byte_r >= ASC_ZERO) && (s1_byte_r <= ASC_NINE);
  assign is_sign  = (s1_byte_r == ASC_PLUS) || (s1_byte_r == ASC_MINUS);
  assign in_window = (32'(pos_r) <= 32'(NUMBER_CHARS));

  // Handshake: a newline moves on only when the result register is free or being read out
  assign s1_adv     = !is_nl || !out_vld_r || out_tready;
  assign in_tready  = !s1_vld_r || s1_adv;
  assign s1_take    = s1_vld_r && s1_adv;
  assign s1_nl_take = s1_take && is_nl;

  // Multiply-by-ten accumulate with saturation
  assign mag_sum = (MAG_W+4)'({mag_r, 3'b000}) + (MAG_W+4)'({mag_r, 1'b0}) +
                   (MAG_W+4)'(s1_byte_r[3:0]);

  // Signed value of the finished line
  assign mag_ext = {1'b0, mag_r};
  assign value   = neg_r ? (~mag_ext + 1'b1) : mag_ext;

  // Command decode
  always_comb begin
    case (letter_r)
      ASC_T:   code_nxt = CMD_THROTTLE;
      ASC_P:   code_nxt = CMD_PITCH;
      ASC_R:   code_nxt = CMD_ROLL;
      ASC_Y:   code_nxt = CMD_YAW;
      default: code_nxt = CMD_NONE;
    endcase
  end

  // Line and number scanner next state
  always_comb begin
    pos_nxt    = pos_r;
    letter_nxt = letter_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    if (pos_r == '0) begin
      letter_nxt = s1_byte_r;
    end else if (in_window) begin
      case (phase_r)
        PH_SKIP: begin
          if (is_sign) begin
            neg_nxt   = (s1_byte_r == ASC_MINUS);
            phase_nxt = PH_DIGITS;
          end else if (!is_space) begin
            if (is_digit) begin
              phase_nxt = PH_DIGITS;
              mag_nxt   = (mag_sum > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX : mag_sum[MAG_W-1:0];
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            mag_nxt = (mag_sum > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX : mag_sum[MAG_W-1:0];
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        default: ;
      endcase
    end
    // Overlong line: drop everything and start fresh
    if (pos_r < POS_W'(LINE_LAST)) begin
      pos_nxt = POS_W'(pos_r + 1'b1);
    end else begin
      pos_nxt    = '0;
      letter_nxt = '0;
      phase_nxt  = PH_SKIP;
      neg_nxt    = 1'b0;
      mag_nxt    = '0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Line state and setpoints
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      letter_r <= '0;
      phase_r  <= PH_SKIP;
      neg_r    <= 1'b0;
      mag_r    <= '0;
      thr_r    <= THROTTLE_RESET;
      pitch_r  <= '0;
      roll_r   <= '0;
      yaw_r    <= '0;
    end else if (s1_nl_take) begin
      pos_r    <= '0;
      letter_r <= '0;
      phase_r  <= PH_SKIP;
      neg_r    <= 1'b0;
      mag_r    <= '0;
      case (code_nxt)
        CMD_THROTTLE: thr_r   <= $signed(value);
        CMD_PITCH:    pitch_r <= $signed(value);
        CMD_ROLL:     roll_r  <= $signed(value);
        CMD_YAW:      yaw_r   <= $signed(value);
        default: ;
      endcase
    end else if (s1_take) begin
      pos_r    <= pos_nxt;
      letter_r <= letter_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_nl_take) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_nl_take) begin
      out_code_r   <= code_nxt;
      out_letter_r <= letter_r;
      out_value_r  <= value;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {yaw_r, roll_r, pitch_r, thr_r, out_value_r, out_letter_r, out_code_r};

`ifndef NO_ASSERTIONS
  // A reported throttle command carries the stored throttle setpoint
  a_thr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_code_r == CMD_THROTTLE)) |-> (thr_r == $signed(out_value_r)))
    else $error("throttle setpoint differs from reported value");

  // Input stalls only behind a newline blocked by a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_vld_r && is_nl && out_vld_r && !out_tready))
    else $error("input stalled without a blocked newline");

  // Magnitude only grows once the scanner has left whitespace skipping
  a_mag_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (mag_r != '0) |-> (phase_r != PH_SKIP))
    else $error("magnitude nonzero while skipping whitespace");

  // A finished line leaves the line state empty
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_nl_take |=> ((pos_r == '0) && (letter_r == '0) && (mag_r == '0) && out_vld_r))
    else $error("line state not cleared after newline");
`endif

endmodule
